FILE: hw/rtl/cdda_pkg.sv
// Shared types, constants and calendar helper functions for the date arithmetic block.
`default_nettype none

package cdda_pkg;

    localparam int MIN_YEAR = 1959;
    localparam int MAX_YEAR = 2099;

    localparam logic [3:0]  DEF_MONTH = 4'd5;
    localparam logic [4:0]  DEF_DAY   = 5'd11;
    localparam logic [11:0] DEF_YEAR  = 12'd1959;

    // Day index counts days from March 1 of a leap year, just after its leap day
    localparam int EPOCH_YEAR = ((MIN_YEAR - 1) / 4) * 4;
    localparam int DN_W       = 17;
    localparam int Q_W        = 6;
    localparam int REM_W      = 11;
    localparam int CYCLE_DAYS = 1461;

    // Reciprocal constants for divide by four-year cycle and by one hundred
    localparam int DIV_SH  = 26;
    localparam int DIV_K   = (1 << DIV_SH) / CYCLE_DAYS;
    localparam int PROD_W  = DN_W + 16;
    localparam int Y100_SH = 19;
    localparam int Y100_K  = (1 << Y100_SH) / 100 + 1;

    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_SUB     = 3'd2;
    localparam logic [2:0] OP_BETWEEN = 3'd3;
    localparam logic [2:0] OP_DOY     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic cap;
        logic cur;
        logic chk;
        logic div1;
        logic div2;
        logic div3;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic needs_div;
    } t_sts;

    // Days before the start of a March-based month (0 = March .. 11 = February)
    function automatic logic [8:0] f_month_base(input logic [3:0] mm);
        logic [8:0] b;
        case (mm)
            4'd0:    b = 9'd0;
            4'd1:    b = 9'd31;
            4'd2:    b = 9'd61;
            4'd3:    b = 9'd92;
            4'd4:    b = 9'd122;
            4'd5:    b = 9'd153;
            4'd6:    b = 9'd184;
            4'd7:    b = 9'd214;
            4'd8:    b = 9'd245;
            4'd9:    b = 9'd275;
            4'd10:   b = 9'd306;
            4'd11:   b = 9'd337;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:                                           n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                        n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:     n = 5'd31;
            default:                                        n = 5'd0;
        endcase
        return n;
    endfunction

    // Day index of a valid date; exact while every century year in range is a leap year
    function automatic logic [DN_W-1:0] f_day_index(input logic [3:0] m,
                                                   input logic [4:0] d,
                                                   input logic [11:0] y);
        logic       early;
        logic [11:0] ys;
        logic [7:0] yy;
        logic [3:0] mm;
        early = (m < 4'd3);
        ys    = y - {11'd0, early} - 12'(EPOCH_YEAR);
        yy    = ys[7:0];
        mm    = early ? (m + 4'd9) : (m - 4'd3);
        return DN_W'(yy) * DN_W'(365) + DN_W'(yy[7:2]) + DN_W'(f_month_base(mm))
               + DN_W'(d) - DN_W'(1);
    endfunction

    localparam logic [DN_W-1:0] DN_LO = f_day_index(4'd1, 5'd1, 12'(MIN_YEAR));
    localparam logic [DN_W-1:0] DN_HI = f_day_index(4'd12, 5'd31, 12'(MAX_YEAR));

endpackage

`default_nettype wire

FILE: hw/rtl/cdda_if.sv
// Valid/ready channel interfaces for commands in and date results out.
`default_nettype none

interface cdda_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [11:0] in_year;
    logic [15:0] day_count;

    modport source (output valid, opcode, in_month, in_day, in_year, day_count,
                    input ready);
    modport sink   (input valid, opcode, in_month, in_day, in_year, day_count,
                    output ready);
endinterface

interface cdda_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [11:0] cur_year;
    logic [15:0] day_result;
    logic [1:0]  status;

    modport source (output valid, cur_month, cur_day, cur_year, day_result, status,
                    input ready);
    modport sink   (input valid, cur_month, cur_day, cur_year, day_result, status,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cdda_ctrl.sv
// Sequencer that steps one command through the datapath and owns the output valid.
`default_nettype none

module cdda_ctrl
    import cdda_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CUR  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV1 = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_DIV3 = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.cap  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.cur  = (r_state == S_CUR);
        o_cmd.chk  = (r_state == S_CHK);
        o_cmd.div1 = (r_state == S_DIV1);
        o_cmd.div2 = (r_state == S_DIV2);
        o_cmd.div3 = (r_state == S_DIV3);
        o_cmd.fin  = (r_state == S_FIN) && slot_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CUR;
            S_CUR:   n_state = S_CHK;
            S_CHK:   n_state = i_sts.needs_div ? S_DIV1 : S_FIN;
            S_DIV1:  n_state = S_DIV2;
            S_DIV2:  n_state = S_DIV3;
            S_DIV3:  n_state = S_FIN;
            // hold the finished result until the output register frees up
            S_FIN:   if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cdda_dp.sv
// Datapath: held date, day index conversions, range checks and the output register.
`default_nettype none

module cdda_dp
    import cdda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [3:0]  i_in_month,
    input  wire logic [4:0]  i_in_day,
    input  wire logic [11:0] i_in_year,
    input  wire logic [15:0] i_day_count,
    output logic [3:0]       o_cur_month,
    output logic [4:0]       o_cur_day,
    output logic [11:0]      o_cur_year,
    output logic [15:0]      o_day_result,
    output logic [1:0]       o_status
);

    // captured command
    logic [2:0]  r_op;
    logic [3:0]  r_m;
    logic [4:0]  r_d;
    logic [11:0] r_y;
    logic [15:0] r_cnt;

    logic [3:0]  r_held_m, n_held_m;
    logic [4:0]  r_held_d, n_held_d;
    logic [11:0] r_held_y, n_held_y;

    logic [DN_W-1:0] r_cur, r_oth, r_nd;
    logic [Q_W-1:0]  r_q100, r_qe, r_q;
    logic [REM_W-1:0] r_rem;
    logic            r_ok, r_oor;
    logic [3:0]      r_new_m;
    logic [4:0]      r_new_d;
    logic [11:0]     r_new_y;

    logic [3:0]  r_out_m;
    logic [4:0]  r_out_d;
    logic [11:0] r_out_y;
    logic [15:0] r_out_res;
    logic [1:0]  r_out_st;

    // step one: held day index and year / 100
    logic [24:0] y100_prod;
    assign y100_prod = 25'(r_y) * 25'(Y100_K);

    // step two: validation, other day index, new day index
    logic [11:0]     r100;
    logic            leap, ok;
    logic [4:0]      mlen;
    logic [3:0]      oth_m;
    logic [4:0]      oth_d;
    logic [11:0]     oth_y;
    logic [DN_W:0]   nd_ext;
    logic            under, oor;

    assign r100 = r_y - 12'(12'(r_q100) * 12'd100);
    assign leap = ((r_y[1:0] == 2'd0) && (r100 != 12'd0))
               || ((r100 == 12'd0) && (r_q100[1:0] == 2'd0));
    assign mlen = f_month_len(r_m, leap);
    assign ok   = (r_m >= 4'd1) && (r_m <= 4'd12) && (r_d >= 5'd1) && (r_d <= mlen)
               && (r_y >= 12'(MIN_YEAR));

    assign oth_m = (r_op == OP_BETWEEN) ? r_m : 4'd1;
    assign oth_d = (r_op == OP_BETWEEN) ? r_d : 5'd1;
    assign oth_y = (r_op == OP_BETWEEN) ? r_y : r_held_y;

    assign under  = (r_op == OP_SUB) && ((DN_W+1)'(r_cnt) > (DN_W+1)'(r_cur));
    assign nd_ext = (r_op == OP_ADD) ? ((DN_W+1)'(r_cur) + (DN_W+1)'(r_cnt))
                                     : ((DN_W+1)'(r_cur) - (DN_W+1)'(r_cnt));
    assign oor    = under || (nd_ext < (DN_W+1)'(DN_LO)) || (nd_ext > (DN_W+1)'(DN_HI));

    // step three: estimate of day index / 1461
    logic [PROD_W-1:0] cyc_prod;
    assign cyc_prod = PROD_W'(r_nd) * PROD_W'(DIV_K);

    // step four: correct the estimate, leaving the remainder below CYCLE_DAYS
    logic [DN_W-1:0] rem0;
    logic            rem_over;
    assign rem0     = r_nd - DN_W'(DN_W'(r_qe) * DN_W'(CYCLE_DAYS));
    assign rem_over = (rem0 >= DN_W'(CYCLE_DAYS));

    // step five: split the remainder into year, month and day
    logic [1:0]  yc;
    logic [8:0]  doy;
    logic [3:0]  mm;
    logic [4:0]  nday;
    logic [3:0]  nmon;
    logic [11:0] nyear;

    always_comb begin
        yc = 2'(r_rem >= 11'd365) + 2'(r_rem >= 11'd730) + 2'(r_rem >= 11'd1095);
        doy = 9'(r_rem - 11'(yc) * 11'd365);
        mm = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy >= f_month_base(4'(k))) mm = 4'(k);
        end
        nday  = 5'(doy - f_month_base(mm) + 9'd1);
        nmon  = (mm < 4'd10) ? (mm + 4'd3) : (mm - 4'd9);
        nyear = 12'(EPOCH_YEAR) + 12'({r_q, 2'b00}) + 12'(yc) + 12'(mm >= 4'd10);
    end

    // final step: pick the outcome for the opcode
    logic [DN_W-1:0] diff;
    logic [15:0]     diff_sat;
    logic [15:0]     n_result;
    logic [1:0]      n_status;
    logic            y_high;

    assign diff     = (r_cur >= r_oth) ? (r_cur - r_oth) : (r_oth - r_cur);
    assign diff_sat = (diff > DN_W'(16'hFFFF)) ? 16'hFFFF : diff[15:0];
    assign y_high   = (r_y > 12'(MAX_YEAR));

    always_comb begin
        n_held_m = r_held_m;
        n_held_d = r_held_d;
        n_held_y = r_held_y;
        n_result = 16'd0;
        n_status = ST_OK;
        case (r_op)
            OP_SET: begin
                if (!r_ok) begin
                    n_held_m = DEF_MONTH;
                    n_held_d = DEF_DAY;
                    n_held_y = DEF_YEAR;
                    n_status = ST_INVALID;
                end else if (y_high) begin
                    n_status = ST_RANGE;
                end else begin
                    n_held_m = r_m;
                    n_held_d = r_d;
                    n_held_y = r_y;
                end
            end
            OP_ADD, OP_SUB: begin
                if (r_oor) begin
                    n_status = ST_RANGE;
                end else begin
                    n_held_m = r_new_m;
                    n_held_d = r_new_d;
                    n_held_y = r_new_y;
                end
            end
            OP_BETWEEN: begin
                if (!r_ok) begin
                    n_status = ST_INVALID;
                end else if (y_high) begin
                    n_status = ST_RANGE;
                end else begin
                    n_result = diff_sat;
                end
            end
            OP_DOY:  n_result = diff_sat;
            default: ;
        endcase
    end

    assign o_sts.needs_div = (r_op == OP_ADD) || (r_op == OP_SUB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_m <= DEF_MONTH;
            r_held_d <= DEF_DAY;
            r_held_y <= DEF_YEAR;
        end else if (i_cmd.fin) begin
            r_held_m <= n_held_m;
            r_held_d <= n_held_d;
            r_held_y <= n_held_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_opcode;
            r_m   <= i_in_month;
            r_d   <= i_in_day;
            r_y   <= i_in_year;
            r_cnt <= i_day_count;
        end
        if (i_cmd.cur) begin
            r_cur  <= f_day_index(r_held_m, r_held_d, r_held_y);
            r_q100 <= y100_prod[Y100_SH +: Q_W];
        end
        if (i_cmd.chk) begin
            r_ok  <= ok;
            r_oth <= f_day_index(oth_m, oth_d, oth_y);
            r_nd  <= nd_ext[DN_W-1:0];
            r_oor <= oor;
        end
        if (i_cmd.div1) begin
            r_qe <= cyc_prod[DIV_SH +: Q_W];
        end
        if (i_cmd.div2) begin
            if (rem_over) begin
                r_q   <= r_qe + Q_W'(1);
                r_rem <= REM_W'(rem0 - DN_W'(CYCLE_DAYS));
            end else begin
                r_q   <= r_qe;
                r_rem <= REM_W'(rem0);
            end
        end
        if (i_cmd.div3) begin
            r_new_m <= nmon;
            r_new_d <= nday;
            r_new_y <= nyear;
        end
        if (i_cmd.fin) begin
            r_out_m   <= n_held_m;
            r_out_d   <= n_held_d;
            r_out_y   <= n_held_y;
            r_out_res <= n_result;
            r_out_st  <= n_status;
        end
    end

    assign o_cur_month  = r_out_m;
    assign o_cur_day    = r_out_d;
    assign o_cur_year   = r_out_y;
    assign o_day_result = r_out_res;
    assign o_status     = r_out_st;

endmodule

`default_nettype wire

FILE: hw/rtl/calendar_date_day_arithmetic.sv
// Top level of the calendar date unit: held Gregorian date with day arithmetic.
//
// Usage: commands enter on i_in (opcode, in_month, in_day, in_year, day_count) and
// each command produces exactly one transfer on o_out with the held date after the
// command, a day count result and a status code. Both channels transfer on a
// rising edge with valid and ready high.
// The result is registered in the final step, after the capture, day index and
// check steps for set, days between and day of year, and after the divide steps
// as well for add and subtract, where the day index goes back to a date through a
// reciprocal multiply, a correction step and a month search. The unit takes one
// command at a time and accepts the next only once the sequencer is back in idle;
// the sequencer walks the datapath steps and is the limit.
// The output register frees the input side: a new command is accepted while the
// previous result still waits. If the receiver stalls, the next command finishes
// its work and holds in the last step until the output register empties.
// Reset (synchronous, active low) loads the held date 1959-05-11, empties the
// output register and returns the sequencer to idle.
`default_nettype none

module calendar_date_day_arithmetic
    import cdda_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdda_in_if.sink    i_in,
    cdda_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    cdda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cdda_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_in.opcode),
        .i_in_month   (i_in.in_month),
        .i_in_day     (i_in.in_day),
        .i_in_year    (i_in.in_year),
        .i_day_count  (i_in.day_count),
        .o_cur_month  (o_out.cur_month),
        .o_cur_day    (o_out.cur_day),
        .o_cur_year   (o_out.cur_year),
        .o_day_result (o_out.day_result),
        .o_status     (o_out.status)
    );

endmodule

`default_nettype wire
